FILE: sv/nibble_sbox_permutation_cipher_macros.svh
// assertion macros for the nibble s-box permutation cipher checker
// no dependencies; included by the checker file only
`ifndef NIBBLE_SBOX_PERMUTATION_CIPHER_MACROS_SVH
`define NIBBLE_SBOX_PERMUTATION_CIPHER_MACROS_SVH

// antecedent and consequent in the same cycle
`define NSPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent in the cycle after the antecedent
`define NSPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/nspc_pkg.sv
// shared types, tables and round functions for the nibble s-box permutation cipher
// no dependencies; imported by nspc_round and the top level
`timescale 1ns / 1ps

package nspc_pkg;

   typedef logic [63:0] block_type;

   localparam int unsigned ROUNDS = 16;
   localparam logic [31:0] KEY_LOW_HALF = 32'h0020_382A;
   localparam int unsigned KEY_ROT_ENC = 12;

   localparam logic [3:0] SBOX_ONE [16] = '{
      4'd12, 4'd10, 4'd8, 4'd4, 4'd3, 4'd15, 4'd0, 4'd2,
      4'd14, 4'd1, 4'd5, 4'd13, 4'd6, 4'd9, 4'd7, 4'd11};

   localparam logic [3:0] SBOX_TWO [16] = '{
      4'd6, 4'd9, 4'd7, 4'd4, 4'd3, 4'd10, 4'd12, 4'd14,
      4'd2, 4'd13, 4'd1, 4'd15, 4'd0, 4'd11, 4'd8, 4'd5};

   localparam logic [5:0] PERM_ENC [64] = '{
      6'd29, 6'd27, 6'd34, 6'd9,  6'd16, 6'd62, 6'd55, 6'd2,
      6'd40, 6'd49, 6'd38, 6'd25, 6'd33, 6'd61, 6'd30, 6'd23,
      6'd1,  6'd41, 6'd21, 6'd57, 6'd42, 6'd15, 6'd5,  6'd58,
      6'd19, 6'd53, 6'd22, 6'd17, 6'd48, 6'd28, 6'd24, 6'd39,
      6'd3,  6'd60, 6'd36, 6'd14, 6'd11, 6'd52, 6'd54, 6'd12,
      6'd31, 6'd51, 6'd10, 6'd26, 6'd0,  6'd45, 6'd37, 6'd43,
      6'd44, 6'd6,  6'd59, 6'd4,  6'd7,  6'd35, 6'd56, 6'd50,
      6'd13, 6'd18, 6'd32, 6'd47, 6'd46, 6'd63, 6'd20, 6'd8};

   localparam logic [5:0] PERM_DEC [64] = '{
      6'd44, 6'd16, 6'd7,  6'd32, 6'd51, 6'd22, 6'd49, 6'd52,
      6'd63, 6'd3,  6'd42, 6'd36, 6'd39, 6'd56, 6'd35, 6'd21,
      6'd4,  6'd27, 6'd57, 6'd24, 6'd62, 6'd18, 6'd26, 6'd15,
      6'd30, 6'd11, 6'd43, 6'd1,  6'd29, 6'd0,  6'd14, 6'd40,
      6'd58, 6'd12, 6'd2,  6'd53, 6'd34, 6'd46, 6'd10, 6'd31,
      6'd8,  6'd17, 6'd20, 6'd47, 6'd48, 6'd45, 6'd60, 6'd59,
      6'd28, 6'd9,  6'd55, 6'd41, 6'd37, 6'd25, 6'd38, 6'd6,
      6'd54, 6'd19, 6'd23, 6'd50, 6'd33, 6'd13, 6'd5,  6'd61};

   // nibble 0 sits in the top four bits; table picked by one bit of the key nibble
   function automatic block_type substitute(block_type data, block_type key,
                                             logic use_bit0);
      block_type res;
      logic [3:0] kn;
      logic [3:0] dn;
      logic       pick_two;
      res = '0;
      for (int n = 0; n < 16; n++) begin
         kn = key[60 - 4*n +: 4];
         dn = data[60 - 4*n +: 4];
         pick_two = use_bit0 ? kn[0] : kn[3];
         res[60 - 4*n +: 4] = pick_two ? SBOX_TWO[dn] : SBOX_ONE[dn];
      end
      return res;
   endfunction

   // input bit i lands on output bit table[i]
   function automatic block_type permute_enc(block_type data);
      block_type res;
      res = '0;
      for (int i = 0; i < 64; i++) begin
         res[PERM_ENC[i]] = data[i];
      end
      return res;
   endfunction

   function automatic block_type permute_dec(block_type data);
      block_type res;
      res = '0;
      for (int i = 0; i < 64; i++) begin
         res[PERM_DEC[i]] = data[i];
      end
      return res;
   endfunction

endpackage

FILE: sv/nspc_round.sv
// one cipher round: substitute and permute, in the order the direction needs
// depends on nspc_pkg for the tables and round functions
`timescale 1ns / 1ps

module nspc_round (
   input  logic                 decrypt,
   input  nspc_pkg::block_type  data_in,
   input  nspc_pkg::block_type  key_in,
   output nspc_pkg::block_type  data_out,
   output nspc_pkg::block_type  key_out
);
   import nspc_pkg::*;

   block_type enc_data;
   block_type dec_data;

   always_comb begin
      enc_data = permute_enc(substitute(data_in, key_in, 1'b0));
      dec_data = substitute(permute_dec(data_in), key_in, 1'b1);
   end

   assign data_out = decrypt ? dec_data : enc_data;
   // key steps left while encrypting, right while decrypting
   assign key_out  = decrypt ? {key_in[0], key_in[63:1]} : {key_in[62:0], key_in[63]};

endmodule

FILE: sv/nibble_sbox_permutation_cipher.sv
// top level of the nibble s-box permutation cipher: csr, input register,
// unrolled rounds and result register; uses nspc_pkg and nspc_round
`timescale 1ns / 1ps

// usage
//   command channel: drive start with req_command (0 encrypt, 1 decrypt) and
//   req_data_block; a transfer happens at each rising edge with start high and
//   busy low. busy stays low, so a new block can be given every cycle.
//   result channel: rsp_strobe is high for exactly one cycle with
//   rsp_result_block; the receiver cannot hold it off and must take it.
//   a transferred block passes through the input register and then the
//   result register before it is shown. throughput: one block per cycle, set
//   by the single register-to-register pass through all rounds.
//   csr: apb-style, station_address at byte address 0 (upper key half);
//   write it only while no block is in flight. pready is always high.
//   reset (synchronous, active high) clears station_address and drops any
//   block in flight; no result is shown for it.
module nibble_sbox_permutation_cipher (
   input  logic         clock,
   input  logic         reset,
   // command channel
   input  logic         start,
   output logic         busy,
   input  logic         req_command,
   input  logic [63:0]  req_data_block,
   // result channel
   output logic         rsp_strobe,
   output logic [63:0]  rsp_result_block,
   // csr port
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import nspc_pkg::*;

   // csr state
   logic [31:0] station_ff, station_in;
   logic        csr_write;

   // input register
   logic        req_valid_ff, req_valid_in;
   logic        req_command_ff, req_command_in;
   block_type   req_data_ff, req_data_in;

   // result register
   logic        rsp_strobe_ff, rsp_strobe_in;
   block_type   rsp_block_ff, rsp_block_in;

   logic        req_transfer;
   block_type   key_base;
   block_type   key_inv;
   block_type   key_first;
   block_type   data_chain [ROUNDS+1];
   block_type   key_chain  [ROUNDS+1];

   assign busy         = 1'b0;
   assign pready       = 1'b1;
   assign req_transfer = start && !busy;

   // register 0 only, at addresses 0 to 3; addresses 4 to 7 are ignored
   assign csr_write = psel && penable && pwrite && pready && !paddr[2];
   assign prdata    = paddr[2] ? 32'd0 : station_ff;

   // key: station address above the fixed low half; encrypt starts from the
   // inverted key rotated right by twelve
   assign key_base  = {station_ff, KEY_LOW_HALF};
   assign key_inv   = ~key_base;
   assign key_first = req_command_ff ? key_base
                                     : {key_inv[KEY_ROT_ENC-1:0], key_inv[63:KEY_ROT_ENC]};

   assign data_chain[0] = req_data_ff;
   assign key_chain[0]  = key_first;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      nspc_round u_round (
         .decrypt  (req_command_ff),
         .data_in  (data_chain[r]),
         .key_in   (key_chain[r]),
         .data_out (data_chain[r+1]),
         .key_out  (key_chain[r+1])
      );
   end

   always_comb begin
      station_in     = csr_write ? pwdata : station_ff;
      req_valid_in   = req_transfer;
      req_command_in = req_command;
      req_data_in    = req_data_block;
      // every registered block yields one result the next cycle
      rsp_strobe_in  = req_valid_ff;
      rsp_block_in   = data_chain[ROUNDS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff    <= '0;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         station_ff    <= station_in;
         req_valid_ff  <= req_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      // payload, no reset needed
      req_command_ff <= req_command_in;
      req_data_ff    <= req_data_in;
      rsp_block_ff   <= rsp_block_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_block = rsp_block_ff;

endmodule

FILE: sv/nspc_checker.sv
// port-level checks for the nibble s-box permutation cipher, bound to the top level
// depends on nibble_sbox_permutation_cipher_macros.svh
`timescale 1ns / 1ps
`include "nibble_sbox_permutation_cipher_macros.svh"

module nspc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [2:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata
);

   // station address write access and read of the same register
   logic st_wr;
   logic st_rd;

   assign st_wr = psel && penable && pwrite && !paddr[2];
   assign st_rd = psel && !pwrite && !paddr[2];

   // each command transfer shows its result once it has passed the input and result registers
   `NSPC_ASSERT_NEXT(a_result_follows, clock, reset, start && !busy, ##1 rsp_strobe)

   // no result appears without a transfer that passed through the input and result registers before it
   `NSPC_ASSERT_SAME(a_no_invented, clock, reset, rsp_strobe, $past(start && !busy, 2))

   // a written station address reads back straight after
   `NSPC_ASSERT_NEXT(a_csr_readback, clock, reset, st_wr, !st_rd || prdata == $past(pwdata))

endmodule

bind nibble_sbox_permutation_cipher nspc_checker u_nspc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .psel       (psel),
   .penable    (penable),
   .pwrite     (pwrite),
   .paddr      (paddr),
   .pwdata     (pwdata),
   .prdata     (prdata)
);
